/* src/frame_rms_envelope_defines.svh */
// ---------------------------------------------------------------------------
// Frame RMS envelope assertion macros
// Concurrent assertion wrappers shared by the RTL; empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef FRAME_RMS_ENVELOPE_DEFINES_SVH
`define FRAME_RMS_ENVELOPE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define FRE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define FRE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define FRE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define FRE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* src/fre_pkg.sv */
// ---------------------------------------------------------------------------
// fre_pkg
// Shared constants, types and state encoding of the frame RMS envelope.
// ---------------------------------------------------------------------------
package fre_pkg;

  // Hop length register.
  localparam int HOP_BITS = 13;
  localparam logic [HOP_BITS-1:0] HOP_RESET = 13'd512;

  // Defaults of the top-level parameters.
  localparam int MAX_HOP_DEF     = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration port.
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam logic REG_HOP_LENGTH = 1'b0;  // register index of hop_length

  // Frame job queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;
  localparam int QCNT_BITS   = 2;

  typedef struct packed {
    logic                 empty;
    logic [QCNT_BITS-1:0] count;
  } fre_qstat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROOT,
    ST_HOLD
  } fre_state_t;

endpackage

/* src/fre_front.sv */
// ---------------------------------------------------------------------------
// fre_front
// Sample intake: squares each sample and accumulates frames into jobs.
// ---------------------------------------------------------------------------
module fre_front #(
  parameter int SAMPLE_BITS = fre_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_HOP     = fre_pkg::MAX_HOP_DEF,
  parameter int SUM_W       = 2 * fre_pkg::SAMPLE_BITS_DEF - 1 + $clog2(fre_pkg::MAX_HOP_DEF)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fre_pkg::HOP_BITS-1:0]  hop_cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        in_sample,
  input  logic                          in_last,
  input  fre_pkg::fre_qstat_t           qstat,
  output logic                          push,
  output logic [SUM_W-1:0]              push_sum,
  output logic [fre_pkg::HOP_BITS-1:0]  push_hop,
  output logic                          push_last
);

  localparam int HB   = fre_pkg::HOP_BITS;
  localparam int SQ_W = 2 * SAMPLE_BITS;
  localparam int CAP_I = (MAX_HOP > (2 ** HB) - 1) ? (2 ** HB) - 1 : MAX_HOP;
  localparam logic [HB-1:0] HOP_CAP = HB'(CAP_I);
  localparam int PC_W = fre_pkg::QCNT_BITS + 1;

  logic [HB-1:0]          cnt_r, cnt_nxt;
  logic [HB-1:0]          hop_eff, taken;
  logic                   fire, accept;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SQ_W-1:0]        sq_w;
  logic [PC_W-1:0]        pend_cnt;

  logic                   a_vld_r;
  logic [SQ_W-1:0]        a_sq_r;
  logic                   a_fire_r;
  logic                   a_last_r;
  logic [HB-1:0]          a_hop_r;

  logic [SUM_W-1:0]       sum_r, sum_nxt, tot;

  // A job pending in stage A keeps its queue slot reserved.
  assign pend_cnt = PC_W'(qstat.count) + PC_W'(a_vld_r && a_fire_r);
  assign in_ready = pend_cnt < PC_W'(fre_pkg::QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (hop_cfg == '0) begin
      hop_eff = HB'(1);
    end else if (hop_cfg > HOP_CAP) begin
      hop_eff = HOP_CAP;
    end else begin
      hop_eff = hop_cfg;
    end
  end

  assign taken = cnt_r + HB'(1);
  assign fire  = taken >= hop_eff;
  assign mag   = in_sample[SAMPLE_BITS-1] ? (~in_sample + SAMPLE_BITS'(1)) : in_sample;
  assign sq_w  = SQ_W'(mag) * SQ_W'(mag);

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = (fire || in_last) ? '0 : taken;
    end
  end

  assign tot = sum_r + SUM_W'(a_sq_r);

  always_comb begin
    sum_nxt = sum_r;
    if (a_vld_r) begin
      sum_nxt = (a_fire_r || a_last_r) ? '0 : tot;
    end
  end

  assign push      = a_vld_r && a_fire_r;
  assign push_sum  = tot;
  assign push_hop  = a_hop_r;
  assign push_last = a_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      a_vld_r <= 1'b0;
      sum_r   <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      a_vld_r <= accept;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_sq_r   <= sq_w;
      a_fire_r <= fire;
      a_last_r <= in_last;
      a_hop_r  <= hop_eff;
    end
  end

endmodule

/* src/fre_queue.sv */
// ---------------------------------------------------------------------------
// fre_queue
// Short FIFO of completed frame jobs between the front and the back.
// ---------------------------------------------------------------------------
`include "frame_rms_envelope_defines.svh"

module fre_queue #(
  parameter int WIDTH = 57
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    pop_data,
  output fre_pkg::fre_qstat_t qstat
);

  localparam int PB = fre_pkg::QPTR_BITS;
  localparam int CB = fre_pkg::QCNT_BITS;

  logic [WIDTH-1:0] mem [fre_pkg::QUEUE_DEPTH];
  logic [PB-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PB-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CB-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PB'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PB'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CB'(push) - CB'(pop);
  end

  assign pop_data    = mem[rd_ptr_r];
  assign qstat.empty = (cnt_r == '0);
  assign qstat.count = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  `FRE_ASSERT_IMP(a_no_overflow, clk, rst_n, push, cnt_r < CB'(fre_pkg::QUEUE_DEPTH), "job queue overflow")
  `FRE_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, cnt_r != '0, "job queue underflow")
  `FRE_ASSERT_NXT(a_cnt_up, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + CB'(1), "queue count lost a push")

endmodule

/* src/fre_back.sv */
// ---------------------------------------------------------------------------
// fre_back
// Per-frame mean (restoring divide) and integer square root, with result register.
// ---------------------------------------------------------------------------
`include "frame_rms_envelope_defines.svh"

module fre_back #(
  parameter int SAMPLE_BITS = fre_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_W       = 2 * fre_pkg::SAMPLE_BITS_DEF - 1 + $clog2(fre_pkg::MAX_HOP_DEF)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fre_pkg::fre_qstat_t          qstat,
  output logic                         pop,
  input  logic [SUM_W-1:0]             job_sum,
  input  logic [fre_pkg::HOP_BITS-1:0] job_hop,
  input  logic                         job_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [SAMPLE_BITS-1:0]       out_rms,
  output logic                         out_last
);

  localparam int HB     = fre_pkg::HOP_BITS;
  localparam int ROOT_W = SAMPLE_BITS;
  localparam int X_W    = 2 * SAMPLE_BITS;
  localparam int REM_W  = SAMPLE_BITS + 2;
  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);
  localparam logic [ROOT_W-1:0] ROOT_MAX  = ROOT_W'(1) << (SAMPLE_BITS - 1);

  fre_pkg::fre_state_t st_r, st_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;

  logic [SUM_W-1:0]    quo_r;
  logic [HB-1:0]       div_r;
  logic [HB-1:0]       rem_r;
  logic                last_r;
  logic [X_W-1:0]      x_r;
  logic [REM_W-1:0]    srem_r;
  logic [ROOT_W-1:0]   root_r;

  logic                out_vld_r;
  logic [ROOT_W-1:0]   out_rms_r;
  logic                out_last_r;

  logic                out_free, load_out;
  logic [HB:0]         rem_sh, rem_sub;
  logic                d_ge;
  logic [SUM_W-1:0]    quo_sh;
  logic [REM_W-1:0]    s_sh, s_trial;
  logic                s_ge;

  assign out_free = !out_vld_r || out_ready;

  // Next state.
  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    case (st_r)
      fre_pkg::ST_IDLE: begin
        if (!qstat.empty) begin
          st_nxt   = fre_pkg::ST_DIV;
          step_nxt = '0;
        end
      end
      fre_pkg::ST_DIV: begin
        if (step_r == DIV_LAST) begin
          st_nxt   = fre_pkg::ST_ROOT;
          step_nxt = '0;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      fre_pkg::ST_ROOT: begin
        if (step_r == ROOT_LAST) begin
          st_nxt = fre_pkg::ST_HOLD;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      fre_pkg::ST_HOLD: begin
        if (out_free) begin
          st_nxt = fre_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = fre_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (st_r)
      fre_pkg::ST_IDLE: pop      = !qstat.empty;
      fre_pkg::ST_HOLD: load_out = out_free;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // One quotient bit per divide step.
  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign d_ge    = rem_sh >= {1'b0, div_r};
  assign quo_sh  = {quo_r[SUM_W-2:0], d_ge};

  // One root bit per square-root step.
  assign s_sh    = {srem_r[REM_W-3:0], x_r[X_W-1:X_W-2]};
  assign s_trial = {root_r, 2'b01};
  assign s_ge    = s_sh >= s_trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= fre_pkg::ST_IDLE;
      step_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      fre_pkg::ST_IDLE: begin
        if (pop) begin
          quo_r  <= job_sum;
          div_r  <= job_hop;
          rem_r  <= '0;
          last_r <= job_last;
        end
      end
      fre_pkg::ST_DIV: begin
        rem_r <= d_ge ? rem_sub[HB-1:0] : rem_sh[HB-1:0];
        quo_r <= quo_sh;
        if (step_r == DIV_LAST) begin
          x_r    <= X_W'(quo_sh);
          srem_r <= '0;
          root_r <= '0;
        end
      end
      fre_pkg::ST_ROOT: begin
        x_r    <= {x_r[X_W-3:0], 2'b00};
        srem_r <= s_ge ? (s_sh - s_trial) : s_sh;
        root_r <= {root_r[ROOT_W-2:0], s_ge};
      end
      fre_pkg::ST_HOLD: begin
        if (load_out) begin
          out_rms_r  <= root_r;
          out_last_r <= last_r;
        end
      end
      default: begin
        rem_r <= rem_r;
      end
    endcase
  end

  assign out_valid = out_vld_r;
  assign out_rms   = out_rms_r;
  assign out_last  = out_last_r;

  `FRE_ASSERT_IMP(a_rem_below_div, clk, rst_n, st_r == fre_pkg::ST_DIV, rem_r < div_r, "divide remainder not below divisor")
  `FRE_ASSERT_NXT(a_div_to_root, clk, rst_n, st_r == fre_pkg::ST_DIV && step_r == DIV_LAST, st_r == fre_pkg::ST_ROOT, "divide did not hand over to root")
  `FRE_ASSERT_NXT(a_rms_range, clk, rst_n, load_out, out_rms_r <= ROOT_MAX, "rms value above full scale")

endmodule

/* src/frame_rms_envelope.sv */
// ---------------------------------------------------------------------------
// frame_rms_envelope
// Framed RMS envelope of a signed sample stream, one result per full frame.
// ---------------------------------------------------------------------------
// Samples arrive on the in_ stream (in_tdata = sample, in_tlast = last sample
// of a data block). They are cut into back-to-back frames of hop_length
// samples; each complete frame yields one transfer on the out_ stream with
// out_tdata = floor(sqrt(floor(sum of squares / hop))) and out_tlast set when
// that frame ended on the block's last sample. A partial frame at block end
// yields nothing and the accumulator restarts.
// The front takes one sample per cycle while in_tready is high. The back
// passes each frame through the idle, divide, root and hold states of its
// shared bit-serial divider and square-root unit; a two-entry job queue lets
// the front keep accumulating meanwhile, so frames at least as long as a
// back-end pass stream at one sample per cycle. Shorter frames are limited to
// one frame per back-end pass, and in_tready drops while the queue is full.
// When the receiver stalls, the result waits in the output register, the back
// waits with the next finished result, then the queue fills and in_tready falls.
// Reset (synchronous, rst_n low) sets hop_length to 512 and clears the
// accumulator, the queue and the output. hop_length (byte address 0 of the cfg_
// port) is to be written only while the block is idle.
// ---------------------------------------------------------------------------
module frame_rms_envelope #(
  parameter int MAX_HOP     = fre_pkg::MAX_HOP_DEF,
  parameter int SAMPLE_BITS = fre_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic                                in_tlast,   // block_last
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    out_tdata,  // [SAMPLE_BITS-1:0] rms_value
  output logic                                out_tlast,  // block_end
  // Configuration port.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [fre_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [fre_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic [fre_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                cfg_pready
);

  localparam int HB      = fre_pkg::HOP_BITS;
  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  // Sum of squares of up to MAX_HOP full-scale samples.
  localparam int SUM_W   = 2 * SAMPLE_BITS - 1 + $clog2(MAX_HOP);
  localparam int JOB_W   = SUM_W + HB + 1;

  logic [HB-1:0]          hop_r, hop_nxt;
  logic                   cfg_wr, reg_sel;

  fre_pkg::fre_qstat_t    qstat;
  logic                   push, pop;
  logic [SUM_W-1:0]       push_sum, job_sum;
  logic [HB-1:0]          push_hop, job_hop;
  logic                   push_last, job_last;
  logic [JOB_W-1:0]       job_in, job_out;
  logic [SAMPLE_BITS-1:0] rms;

  // Register file: hop_length is the only register; address bit 2 picks it.
  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[2] == fre_pkg::REG_HOP_LENGTH);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign hop_nxt    = (cfg_wr && reg_sel) ? cfg_pwdata[HB-1:0] : hop_r;
  assign cfg_prdata = reg_sel ? fre_pkg::CFG_DATA_BITS'(hop_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_r <= fre_pkg::HOP_RESET;
    end else begin
      hop_r <= hop_nxt;
    end
  end

  fre_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_HOP     (MAX_HOP),
    .SUM_W       (SUM_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .hop_cfg   (hop_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .in_last   (in_tlast),
    .qstat     (qstat),
    .push      (push),
    .push_sum  (push_sum),
    .push_hop  (push_hop),
    .push_last (push_last)
  );

  assign job_in = {push_last, push_hop, push_sum};

  fre_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (job_in),
    .pop       (pop),
    .pop_data  (job_out),
    .qstat     (qstat)
  );

  assign job_sum  = job_out[SUM_W-1:0];
  assign job_hop  = job_out[SUM_W+HB-1:SUM_W];
  assign job_last = job_out[JOB_W-1];

  fre_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .pop       (pop),
    .job_sum   (job_sum),
    .job_hop   (job_hop),
    .job_last  (job_last),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rms   (rms),
    .out_last  (out_tlast)
  );

  assign out_tdata = TDATA_W'(rms);

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Frame RMS envelope testbench
// Streams signed samples into the block and compares every result transfer
// with an in-bench prediction of the framed RMS, over a range of hop lengths.
// ----------------------------------------------------------------------------
// A short directed table runs first. It covers full-scale samples, a hop of
// zero, a partial frame at block end, a frame that ends exactly on the block's
// last sample, a hop change part way through a frame and a write to an unused
// register. Random phases follow, one per hop setting, from a hop of 1 up to
// a saturated hop of 8191. The sender works in bursts with random gaps. The
// receiver stalls on patterns of its own and once holds off long enough that
// the block stops accepting input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_W = fre_pkg::CFG_ADDR_BITS;
  localparam int DATA_W = fre_pkg::CFG_DATA_BITS;
  localparam int HOP_W = fre_pkg::HOP_BITS;
  localparam int MAX_HOP = fre_pkg::MAX_HOP_DEF;

  localparam int CLK_HALF_NS = 5;
  localparam int RESET_CYCLES = 7;
  // This margin is well past the point where a partial frame, which causes no
  // result, has been dealt with.
  localparam int SETTLE_CYCLES = 200;
  // The receiver's long hold-off. It is far longer than it takes the two-entry
  // job queue to fill when the hop is 1.
  localparam int LONG_HOLD_CYCLES = 800;
  localparam int TIMEOUT_NS = 20_000_000;
  localparam int MAX_PRINTS = 60;

  // Byte addresses on the configuration port. Index 1 has no register behind it.
  localparam logic [ADDR_W-1:0] ADDR_HOP = ADDR_W'(fre_pkg::REG_HOP_LENGTH) << 2;
  localparam logic [ADDR_W-1:0] ADDR_UNUSED = ADDR_W'(1) << 2;

  // One expected result transfer.
  typedef struct packed {
    logic [15:0] rms;
    logic        block_end;
  } envelope_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_READ,
    ROW_SAMPLE
  } row_kind_t;

  // One row of the directed table. When typed is set, the expected outcome
  // comes from the row itself rather than from the predictor.
  typedef struct {
    row_kind_t                 kind;
    logic [ADDR_W-1:0]         addr;
    logic [31:0]               wdata;
    logic signed [15:0]        smp;
    logic                      lst;
    bit                        typed;
    bit                        hit;
    logic [15:0]               rms;
    logic                      block_end;
  } dir_row_t;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_COMB,
    RX_MOSTLY
  } rx_mode_t;

  // Every input of the block starts out at a known value.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;       // [15:0] sample
  logic in_tlast = 1'b0;            // block_last
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;           // [15:0] rms_value
  logic out_tlast;                  // block_end
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  frame_rms_envelope u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // The bench's own copy of the block's state. It is kept in step with every
  // accepted sample and every register write.
  logic [HOP_W-1:0] hop_reg = fre_pkg::HOP_RESET;
  logic [63:0]      sq_acc = '0;
  int               taken = 0;

  envelope_t rms_expected[$];
  int        mismatches = 0;
  int        long_holds_asked = 0;
  int        burst_left = 0;
  dir_row_t  directed[$];

  // Prints one line per mismatch, up to a cap, and counts every one of them.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("mismatch at %0t: %s, got %0d, want %0d", $realtime, what, got, want);
    end
  endtask

  // A hop register of zero acts as 1, and anything above MAX_HOP saturates.
  function automatic int hop_effective(input logic [HOP_W-1:0] h);
    if (h == '0) begin
      return 1;
    end
    if (int'(h) > MAX_HOP) begin
      return MAX_HOP;
    end
    return int'(h);
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) begin
        r = t;
      end
    end
    return r;
  endfunction

  // Takes one sample into the frame. A frame completes once the count of
  // samples taken reaches the hop in force at that sample, even if the hop was
  // lowered part way through the frame. A block's last sample always clears
  // the frame, whether or not the frame was complete.
  function automatic void step_envelope(input logic signed [15:0] smp, input logic lst,
                                        output bit hit, output envelope_t res);
    int mag;
    int eff;
    mag = int'(smp);
    if (mag < 0) begin
      mag = -mag;
    end
    sq_acc += 64'(mag) * 64'(mag);
    taken++;
    eff = hop_effective(hop_reg);
    hit = 1'b0;
    res = '0;
    if (taken >= eff) begin
      hit = 1'b1;
      res.rms = 16'(root_floor(sq_acc / 64'(eff)));
      res.block_end = lst;
      sq_acc = '0;
      taken = 0;
    end else if (lst) begin
      sq_acc = '0;
      taken = 0;
    end
  endfunction

  // Offers one sample and holds it until the block accepts it. tvalid is not
  // lowered here, so that back-to-back calls keep it high without a gap.
  task automatic push_sample(input logic signed [15:0] smp, input logic lst,
                             output bit hit, output envelope_t res);
    in_tvalid <= 1'b1;
    in_tdata <= smp;
    in_tlast <= lst;
    do @(posedge clk); while (!in_tready);
    step_envelope(smp, lst, hit, res);
  endtask

  // Stops offering input and waits until every expected result has arrived.
  // The block sees tvalid low before the task returns.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (rms_expected.size() != 0);
  endtask

  // Register writes happen only on an idle block. The settle time covers a
  // trailing partial frame that is still in the block, since it causes no
  // result that could be waited for.
  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == ADDR_HOP) begin
      hop_reg = data[HOP_W-1:0];
    end
    @(posedge clk);
  endtask

  // Reads a register and checks it against the bench's copy. Only one
  // register exists, so any read compares with the hop length.
  task automatic cfg_read_check(input logic [ADDR_W-1:0] addr);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== DATA_W'(hop_reg)) begin
      report_mismatch("hop_length read back", cfg_prdata, hop_reg);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Sample values are weighted toward the extremes and toward small values.
  // Full random values make sure every bit is exercised.
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($signed($urandom_range(0, 32)) - 16);
      3: return 16'sh0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic void add_write(input logic [ADDR_W-1:0] addr, input logic [31:0] v);
    dir_row_t r;
    r = '{kind: ROW_WRITE, addr: addr, wdata: v, default: '0};
    directed = {directed, r};
  endfunction

  function automatic void add_read(input logic [ADDR_W-1:0] addr);
    dir_row_t r;
    r = '{kind: ROW_READ, addr: addr, default: '0};
    directed = {directed, r};
  endfunction

  function automatic void add_sample(input logic signed [15:0] s, input logic lst);
    dir_row_t r;
    r = '{kind: ROW_SAMPLE, smp: s, lst: lst, default: '0};
    directed = {directed, r};
  endfunction

  function automatic void add_typed(input logic signed [15:0] s, input logic lst, input bit hit,
                                    input logic [15:0] rms, input logic block_end);
    dir_row_t r;
    r = '{kind: ROW_SAMPLE, smp: s, lst: lst, typed: 1'b1, hit: hit, rms: rms,
          block_end: block_end, default: '0};
    directed = {directed, r};
  endfunction

  // One random phase at a single hop setting. With a hop up to 512, most blocks
  // are a whole number of frames long; others may end part way through a frame.
  // The last item of the phase always closes its block. A phase may also ask for
  // the long receiver hold-off, or pause the sender until all results are in.
  task automatic run_phase(input int hop_value, input int n_items, input int hold_at,
                           input int pause_at, input bit whole_block);
    int eff;
    int block_left;
    int gap;
    logic lst;
    bit hit;
    envelope_t res;
    // The upper bits of the write data are random, since the register keeps
    // only its low 13 bits.
    cfg_write(ADDR_HOP, ($urandom() & ~32'h1fff) | 32'(hop_value[HOP_W-1:0]));
    cfg_read_check(ADDR_HOP);
    eff = hop_effective(hop_reg);
    block_left = 0;
    gap = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) begin
        long_holds_asked++;
      end
      if (block_left == 0) begin
        if (whole_block) begin
          block_left = n_items;
        end else if (eff <= 512 && $urandom_range(0, 9) < 7) begin
          block_left = eff * $urandom_range(1, 4);
        end else begin
          block_left = $urandom_range(1, (eff <= 64) ? 3 * eff + 2 : 200);
        end
      end
      block_left--;
      lst = (block_left == 0) || (i == n_items - 1);
      if (lst) begin
        block_left = 0;
      end
      // Bursts of random length, mostly with short gaps between them. Now and
      // then a gap is long, and now and then there is none at all.
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0
              : $urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 5);
      end
      burst_left--;
      if (i == pause_at) begin
        wait_drained();
      end else if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        gap = 0;
      end
      push_sample(pick_sample(), lst, hit, res);
      if (hit) begin
        rms_expected = {rms_expected, res};
      end
    end
  endtask

  // The receiver moves between stall patterns of random length. Once the
  // stimulus asks for it, it holds out_tready low for a long count of cycles.
  initial begin : receiver
    int served;
    int hold_left;
    int mode_left;
    int comb_ctr;
    rx_mode_t mode;
    served = 0;
    hold_left = 0;
    mode_left = 0;
    comb_ctr = 0;
    mode = RX_OPEN;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && long_holds_asked > served) begin
        served++;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        comb_ctr++;
        case (mode)
          RX_OPEN: out_tready <= 1'b1;
          RX_COIN: out_tready <= ($urandom_range(0, 1) == 1);
          RX_COMB: out_tready <= (comb_ctr % 4 == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Every result transfer is checked against the oldest expectation, one
  // field at a time.
  always @(posedge clk) begin : result_check
    envelope_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (rms_expected.size() == 0) begin
        report_mismatch("result transfer with nothing expected", out_tdata, 0);
      end else begin
        want = rms_expected.pop_front();
        if (out_tdata !== want.rms) begin
          report_mismatch("rms_value", out_tdata, want.rms);
        end
        if (out_tlast !== want.block_end) begin
          report_mismatch("block_end", out_tlast, want.block_end);
        end
      end
    end
  end

  initial begin : watchdog
    #TIMEOUT_NS;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    bit hit;
    envelope_t res;

    // Right after reset the register reads back 512. At a hop of 1, every
    // sample is its own frame and its result is the sample's magnitude.
    // Negative full scale gives 32768.
    add_read(ADDR_HOP);
    add_write(ADDR_HOP, 32'd1);
    add_typed(16'sh8000, 1'b0, 1'b1, 16'd32768, 1'b0);
    add_typed(16'sh7fff, 1'b0, 1'b1, 16'd32767, 1'b0);
    add_typed(16'sh0000, 1'b0, 1'b1, 16'd0, 1'b0);
    add_typed(-16'sd1, 1'b1, 1'b1, 16'd1, 1'b1);
    // A hop of zero acts as a hop of one.
    add_write(ADDR_HOP, 32'd0);
    add_read(ADDR_HOP);
    add_typed(-16'sd32767, 1'b1, 1'b1, 16'd32767, 1'b1);
    add_typed(16'sd12345, 1'b0, 1'b1, 16'd12345, 1'b0);
    // Hop of 3. A two-sample block is a partial frame that is dropped. Then
    // comes a full frame, and then a frame that ends on the block's last sample.
    add_write(ADDR_HOP, 32'd3);
    add_typed(16'sd100, 1'b0, 1'b0, 16'd0, 1'b0);
    add_typed(16'sd200, 1'b1, 1'b0, 16'd0, 1'b0);
    add_sample(16'sd300, 1'b0);
    add_sample(-16'sd400, 1'b0);
    add_sample(16'sd500, 1'b0);
    add_sample(16'sd1, 1'b0);
    add_sample(16'sd2, 1'b0);
    add_sample(16'sd3, 1'b1);
    // The hop drops from 4 to 2 after three samples of a frame. That frame
    // then completes on the next sample and is divided by 2.
    add_write(ADDR_HOP, 32'd4);
    add_sample(16'sd1000, 1'b0);
    add_sample(16'sd2000, 1'b0);
    add_sample(16'sd3000, 1'b0);
    add_write(ADDR_HOP, 32'd2);
    add_sample(16'sd4000, 1'b0);
    // A write to an index with no register behind it changes nothing.
    add_write(ADDR_UNUSED, 32'hffff_ffff);
    add_read(ADDR_HOP);
    add_sample(-16'sd5, 1'b0);
    add_sample(16'sd5, 1'b1);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      case (directed[i].kind)
        ROW_WRITE: begin
          cfg_write(directed[i].addr, directed[i].wdata);
        end
        ROW_READ: begin
          cfg_read_check(directed[i].addr);
        end
        default: begin
          push_sample(directed[i].smp, directed[i].lst, hit, res);
          if (directed[i].typed) begin
            if (directed[i].hit) begin
              res.rms = directed[i].rms;
              res.block_end = directed[i].block_end;
              rms_expected = {rms_expected, res};
            end
          end else if (hit) begin
            rms_expected = {rms_expected, res};
          end
        end
      endcase
    end

    // Random phases. The hop-of-1 phase asks for the long hold-off, so the
    // job queue fills and the input stalls while samples keep being offered.
    // The hop of 8191 saturates to 4096, so its short block is a dropped
    // partial frame.
    run_phase(1, 120, 20, -1, 1'b0);
    run_phase(2, 80, -1, -1, 1'b0);
    run_phase(3, 80, -1, 40, 1'b0);
    run_phase(8191, 40, -1, -1, 1'b1);
    run_phase(0, 50, -1, -1, 1'b0);
    run_phase(5, 70, -1, -1, 1'b0);
    run_phase(17, 80, -1, -1, 1'b0);
    run_phase(61, 90, -1, -1, 1'b0);
    run_phase(64, 90, -1, -1, 1'b0);
    run_phase($urandom_range(1, 30), 60, -1, -1, 1'b0);
    run_phase(100, 120, -1, -1, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
